// ----- hdl/itoa_pkg.sv -----
package itoa_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int CAP_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

    typedef struct packed {
        logic             neg;
        logic             hex;
        logic [CAP_W-1:0] room;
    } t_job_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ----- hdl/itoa_front.sv -----
module itoa_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_value_bits,
    input  logic                          i_is_signed,
    input  logic                          i_base_hex,
    input  logic [itoa_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [VALUE_WIDTH-1:0]        o_mag,
    output itoa_pkg::t_job_ctl            o_ctl
);

    logic [VALUE_WIDTH-1:0] v;
    logic                   neg;

    assign v   = i_value_bits[VALUE_WIDTH-1:0];
    assign neg = i_is_signed && v[VALUE_WIDTH-1];

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_mag   = neg ? (~v + VALUE_WIDTH'(1)) : v;

    always_comb begin
        o_ctl.neg  = neg;
        o_ctl.hex  = i_base_hex;
        o_ctl.room = (i_capacity > itoa_pkg::CAP_W'(1)) ?
                     (i_capacity - itoa_pkg::CAP_W'(1)) : '0;
    end

endmodule

// ----- hdl/itoa_queue.sv -----
module itoa_queue #(
    parameter int DATA_W = 38
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/itoa_back.sv -----
module itoa_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  logic [VALUE_WIDTH-1:0]          i_job_mag,
    input  itoa_pkg::t_job_ctl              i_job_ctl,
    output logic                            o_job_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [itoa_pkg::CHAR_W-1:0]     o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tuser
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIGIT = 6'b000100,
        S_SIGN  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_EMPTY = 6'b100000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [VALUE_WIDTH-1:0]          r_mag;
    logic [63:0]                     r_prod;
    logic                            r_neg;
    logic                            r_hex;
    logic [itoa_pkg::CAP_W-1:0]      r_room;
    logic [3:0]                      r_cnt;
    logic [itoa_pkg::DIGIT_W-1:0]    r_buf [itoa_pkg::MAX_DIGITS];
    logic                            r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]     r_out_char;
    logic                            r_out_last;
    logic                            r_out_empty;

    logic                            slot_free;
    logic [31:0]                     q32;
    logic [31:0]                     rem32;
    logic [itoa_pkg::DIGIT_W-1:0]    digit;
    logic [VALUE_WIDTH-1:0]          next_mag;
    logic                            conv_done;
    logic                            emit_last;

    assign slot_free = !r_out_valid || i_m_tready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign q32      = {3'b000, r_prod[63:itoa_pkg::RECIP10_SHIFT]};
    assign rem32    = 32'(r_mag) - (q32 << 3) - (q32 << 1);
    assign digit    = r_hex ? r_mag[3:0] : rem32[3:0];
    assign next_mag = r_hex ? (r_mag >> 4) : q32[VALUE_WIDTH-1:0];
    assign conv_done = (next_mag == '0) || (r_cnt == 4'(itoa_pkg::MAX_DIGITS - 1));
    assign emit_last = (r_room == itoa_pkg::CAP_W'(1)) || (r_cnt == 4'd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job_ctl.room == '0) begin
                        n_state = S_EMPTY;
                    end else if (i_job_ctl.hex) begin
                        n_state = S_DIGIT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: n_state = S_DIGIT;
            S_DIGIT: begin
                if (conv_done) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end else begin
                    n_state = r_hex ? S_DIGIT : S_MUL;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    n_state = (r_room == itoa_pkg::CAP_W'(1)) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mag  <= i_job_mag;
                r_neg  <= i_job_ctl.neg;
                r_hex  <= i_job_ctl.hex;
                r_room <= i_job_ctl.room;
                r_cnt  <= 4'd0;
            end
            S_MUL: begin
                r_prod <= 64'(r_mag) * 64'(itoa_pkg::RECIP10);
            end
            S_DIGIT: begin
                r_buf[r_cnt] <= digit;
                r_mag        <= next_mag;
                if (!conv_done) begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    r_room <= r_room - itoa_pkg::CAP_W'(1);
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    r_room <= r_room - itoa_pkg::CAP_W'(1);
                    if (r_cnt != 4'd0) begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            case (r_state)
                S_SIGN: begin
                    r_out_char  <= itoa_pkg::CHAR_MINUS;
                    r_out_last  <= (r_room == itoa_pkg::CAP_W'(1));
                    r_out_empty <= 1'b0;
                end
                S_EMIT: begin
                    r_out_char  <= itoa_pkg::digit_char(r_buf[r_cnt]);
                    r_out_last  <= emit_last;
                    r_out_empty <= 1'b0;
                end
                S_EMPTY: begin
                    r_out_char  <= '0;
                    r_out_last  <= 1'b1;
                    r_out_empty <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) begin
                r_out_valid <= (r_state == S_SIGN) || (r_state == S_EMIT) ||
                               (r_state == S_EMPTY);
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_empty;

`ifndef SYNTHESIS
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < 4'(itoa_pkg::MAX_DIGITS))
        else $error("digit index out of range");

    a_room_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SIGN) |-> r_room != '0)
        else $error("emitting with no room left");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty result not marked last");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> r_state != S_IDLE)
        else $error("job popped but back end stayed idle");
`endif

endmodule

// ----- hdl/integer_to_ascii_formatter.sv -----
// Integer-to-ASCII formatter. Each input transaction converts one value (signed or
// unsigned, base 10 or 16) into lower-case ASCII characters, most significant first,
// with a leading '-' for negative signed values; one output transaction per character,
// tlast on the final one. At most capacity-1 characters are sent (low digits dropped);
// when none fit, one transaction with tuser=1 and tlast=1 is sent. Inputs are classified
// and queued (two deep), so the input side keeps accepting while a conversion runs.
// The back end handles one value at a time: a start step, then per digit a reciprocal
// multiply and then a remainder step in decimal, or a single step in hex, then a step
// per character sent, each of which waits while the output is stalled.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] value_bits, [35:32] capacity, [39:36] zero
    input  logic [1:0]  i_s_tuser,   // [0] is_signed, [1] base_hex
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] char_code
    output logic        o_m_tlast,   // is_last
    output logic        o_m_tuser    // [0] empty_res
);

    localparam int JOB_W = VALUE_WIDTH + $bits(itoa_pkg::t_job_ctl);

    logic                   q_full;
    logic                   push;
    logic [VALUE_WIDTH-1:0] f_mag;
    itoa_pkg::t_job_ctl     f_ctl;
    logic                   pop;
    logic                   q_valid;
    logic [JOB_W-1:0]       q_data;
    itoa_pkg::t_job_ctl     b_ctl;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_value_bits (i_s_tdata[31:0]),
        .i_is_signed  (i_s_tuser[0]),
        .i_base_hex   (i_s_tuser[1]),
        .i_capacity   (i_s_tdata[35:32]),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_mag        (f_mag),
        .o_ctl        (f_ctl)
    );

    itoa_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_mag}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_ctl = q_data[JOB_W-1:VALUE_WIDTH];

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job_mag   (q_data[VALUE_WIDTH-1:0]),
        .i_job_ctl   (b_ctl),
        .o_job_pop   (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ----- sim/tb_integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

    typedef struct packed {
        logic [31:0] value;
        logic        is_signed;
        logic        base_hex;
        logic [3:0]  capacity;
    } t_conversion;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       empty;
    } t_char_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // [31:0] value_bits, [35:32] capacity, [39:36] zero
    logic [1:0]  i_s_tuser = '0;   // [0] is_signed, [1] base_hex
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [7:0] char_code
    logic        o_m_tlast;
    logic        o_m_tuser;        // [0] empty_res

    t_conversion pending_conversions[$];
    t_char_beat  expected_chars[$];
    t_conversion next_conv;
    t_conversion taken_conv;
    t_char_beat  want_char;
    bit          in_fire = 1'b0;
    bit          failed = 1'b0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    integer_to_ascii_formatter #(.VALUE_WIDTH(32)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected characters of one conversion, most significant first.
    function automatic void predict_characters(input t_conversion c);
        logic [3:0]  digits[itoa_pkg::MAX_DIGITS];
        logic [31:0] mag;
        logic        neg;
        int unsigned radix;
        int          n_digits;
        int          room;
        int          total;
        int          idx;
        t_char_beat  beat;
        neg = c.is_signed && c.value[31];
        mag = neg ? 32'd0 - c.value : c.value;
        radix = c.base_hex ? 16 : 10;
        n_digits = 0;
        if (mag == 0) begin
            digits[0] = 4'd0;
            n_digits = 1;
        end else begin
            while (mag != 0 && n_digits < itoa_pkg::MAX_DIGITS) begin
                digits[n_digits] = 4'(mag % radix);
                mag = mag / radix;
                n_digits++;
            end
        end
        room = (c.capacity > 0) ? int'(c.capacity) - 1 : 0;
        if (neg && c.capacity < 2)
            room = 0;
        if (room == 0) begin
            beat = '{code: 8'd0, last: 1'b1, empty: 1'b1};
            expected_chars.push_back(beat);
            return;
        end
        total = n_digits + (neg ? 1 : 0);
        if (total > room)
            total = room;
        for (int e = 0; e < total; e++) begin
            if (neg && e == 0) begin
                beat.code = itoa_pkg::CHAR_MINUS;
            end else begin
                idx = n_digits - 1 - (e - (neg ? 1 : 0));
                beat.code = (digits[idx] < 10) ?
                            itoa_pkg::CHAR_ZERO + 8'(digits[idx]) :
                            itoa_pkg::CHAR_A + 8'(digits[idx] - 4'd10);
            end
            beat.last = (e == total - 1);
            beat.empty = 1'b0;
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic void queue_conversion(input logic [31:0] v, input logic sgn,
                                             input logic hex, input logic [3:0] cap);
        t_conversion c;
        c = '{value: v, is_signed: sgn, base_hex: hex, capacity: cap};
        pending_conversions.push_back(c);
    endfunction

    function automatic void queue_random_conversion();
        logic [31:0] v;
        logic [3:0]  cap;
        case ($urandom_range(5))
            0: v = $urandom >> $urandom_range(31);
            1: v = 32'd0 - ($urandom >> $urandom_range(31));
            2: begin
                case ($urandom_range(7))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7fff_ffff;
                    3: v = 32'h8000_0000;
                    4: v = 32'hffff_ffff;
                    5: v = 32'h8000_0001;
                    6: v = 32'd1_000_000_000;
                    default: v = 32'd999_999_999;
                endcase
            end
            default: v = $urandom;
        endcase
        cap = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(15, 11));
        queue_conversion(v, 1'($urandom_range(1)), 1'($urandom_range(1)), cap);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || in_fire)) begin
            if (pending_conversions.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_conv = pending_conversions.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {4'd0, next_conv.capacity, next_conv.value};
                i_s_tuser <= {next_conv.base_hex, next_conv.is_signed};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                in_fire = 1'b1;
                taken_conv = '{value: i_s_tdata[31:0], is_signed: i_s_tuser[0],
                               base_hex: i_s_tuser[1], capacity: i_s_tdata[35:32]};
                predict_characters(taken_conv);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transaction: char_code %h is_last %b empty_res %b",
                           o_m_tdata, o_m_tlast, o_m_tuser);
                    failed = 1'b1;
                end else begin
                    want_char = expected_chars.pop_front();
                    // char_code carries no meaning on an empty result
                    if (!want_char.empty && o_m_tdata !== want_char.code) begin
                        $error("char_code: expected %h, got %h", want_char.code, o_m_tdata);
                        failed = 1'b1;
                    end
                    if (o_m_tlast !== want_char.last) begin
                        $error("is_last: expected %b, got %b", want_char.last, o_m_tlast);
                        failed = 1'b1;
                    end
                    if (o_m_tuser !== want_char.empty) begin
                        $error("empty_res: expected %b, got %b", want_char.empty, o_m_tuser);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_conversion(32'h0000_0000, 1'b0, 1'b0, 4'd15);
        queue_conversion(32'h0000_0000, 1'b1, 1'b1, 4'd2);
        queue_conversion(32'hffff_ffff, 1'b0, 1'b0, 4'd15);
        queue_conversion(32'hffff_ffff, 1'b1, 1'b0, 4'd15);
        queue_conversion(32'h8000_0000, 1'b1, 1'b0, 4'd15);
        queue_conversion(32'h8000_0000, 1'b1, 1'b1, 4'd15);
        queue_conversion(32'h8000_0000, 1'b0, 1'b0, 4'd15);
        queue_conversion(32'h7fff_ffff, 1'b1, 1'b0, 4'd15);
        queue_conversion(32'hffff_ffff, 1'b0, 1'b1, 4'd15);
        queue_conversion(32'hdead_beef, 1'b0, 1'b1, 4'd15);
        queue_conversion(32'hfedc_ba98, 1'b1, 1'b1, 4'd15);
        queue_conversion(32'd1234, 1'b0, 1'b0, 4'd0);
        queue_conversion(32'd1234, 1'b0, 1'b1, 4'd1);
        queue_conversion(32'hffff_ff85, 1'b1, 1'b0, 4'd0);
        queue_conversion(32'hffff_ff85, 1'b1, 1'b0, 4'd1);
        queue_conversion(32'hffff_ff85, 1'b1, 1'b0, 4'd2);
        queue_conversion(32'h0000_0000, 1'b1, 1'b0, 4'd1);
        queue_conversion(32'd123_456_789, 1'b0, 1'b0, 4'd4);
        queue_conversion(32'hf8a4_32eb, 1'b1, 1'b0, 4'd5);
        queue_conversion(32'd1_234_567_890, 1'b1, 1'b0, 4'd11);
        queue_conversion(32'd4_000_000_000, 1'b0, 1'b0, 4'd10);
        queue_conversion(32'h0000_000a, 1'b0, 1'b1, 4'd2);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            for (int n = 0; n < 45; n++)
                queue_random_conversion();
            while (pending_conversions.size() != 0 || i_s_tvalid || expected_chars.size() != 0)
                @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (!failed) begin
            $display("integer_to_ascii_formatter test passed");
        end else begin
            $display("integer_to_ascii_formatter test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("integer_to_ascii_formatter test failed");
        $finish;
    end

endmodule
